// ===== hdl/assert_macros.svh =====
// Assertion shorthands used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/gqe_pkg.sv =====
package gqe_pkg;

   // Item fields on the stream ports
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 120;
   localparam int CMD_W      = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int POS_W       = 24;
   localparam int SUM_W       = 26;
   localparam int TEX_W       = 12;
   localparam int ATLAS_W     = 11;
   localparam int DEPTH_IDX_W = 15;
   localparam int SCALE_W     = 12;
   localparam int COLOR_W     = 32;

   // Scaled glyph quantities
   localparam int OFS_PROD_W = 21;
   localparam int DIM_PROD_W = 20;
   localparam int ADV_PROD_W = 22;

   // Commands carried on req_tuser
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd2;

   // Register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_TEXT_SCALE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KERN_BIAS  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TEXT_COLOR = 2'd2;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 12'h100;
   localparam logic [7:0]         KERN_RESET  = 8'hF8;
   localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hFFFF_FFFF;

   // Vertex slots within one quad
   localparam logic [2:0] VERT_0    = 3'd0;
   localparam logic [2:0] VERT_1    = 3'd1;
   localparam logic [2:0] VERT_2    = 3'd2;
   localparam logic [2:0] VERT_3    = 3'd3;
   localparam logic [2:0] VERT_4    = 3'd4;
   localparam logic [2:0] VERT_LAST = 3'd5;

   typedef struct packed {
      logic [7:0]         advance;
      logic [7:0]         offset_y;
      logic [7:0]         offset_x;
      logic [7:0]         glyph_h;
      logic [7:0]         glyph_w;
      logic [ATLAS_W-1:0] atlas_y;
      logic [ATLAS_W-1:0] atlas_x;
   } glyph_type;

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(24'sh7F_FFFF);
      lo = -(SUM_W'(24'sh40_0000) <<< 1);
      if (v > hi) begin
         return 24'h7F_FFFF;
      end else if (v < lo) begin
         return 24'h80_0000;
      end else begin
         return v[POS_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/glyph_quad_emitter.sv =====
// Glyph quad emitter: each draw item (req_tuser = draw) looks up its glyph and
// yields six vertices, two triangles of one textured quad, with rsp_tlast on
// the sixth; load items fill the glyph table and start items set the pen, and
// neither yields output. Items enter a four-stage pipeline (table read, scale
// products, pen update, quad corners); loads and starts leave at the pen
// update. A draw holds the output, one vertex per accepted beat, until its
// sixth is taken; loads and starts go one per cycle unless a stalled draw
// holds the pipeline. The glyph table reads as all zero after reset; the user
// must write the csr registers only while no item is in flight; not enforced.
module glyph_quad_emitter #(
   parameter int GLYPH_ENTRIES = 128,
   parameter int DEPTH_STEPS   = 32767
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // char_code, atlas_x, atlas_y, glyph_w, glyph_h, offset_x, offset_y,
   // advance, start_x, start_y, zero pad
   input  logic [gqe_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd
   input  logic [gqe_pkg::CMD_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // vert_x, vert_y, tex_u, tex_v, depth_index, vert_color, zero pad
   output logic [gqe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [gqe_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [gqe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W   = $clog2(GLYPH_ENTRIES);
   localparam int DEPTH_W = $clog2(DEPTH_STEPS + 1);
   localparam logic [16:0]        ENTRY_LIM = 17'(GLYPH_ENTRIES);
   localparam logic [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(DEPTH_STEPS);

   // ---------------- configuration ----------------
   logic [gqe_pkg::SCALE_W-1:0] scale_ff;
   logic [7:0]                  kern_ff;
   logic [gqe_pkg::COLOR_W-1:0] color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= gqe_pkg::SCALE_RESET;
         kern_ff  <= gqe_pkg::KERN_RESET;
         color_ff <= gqe_pkg::COLOR_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            gqe_pkg::CSR_TEXT_SCALE: scale_ff <= csr_wdata[gqe_pkg::SCALE_W-1:0];
            gqe_pkg::CSR_KERN_BIAS:  kern_ff  <= csr_wdata[7:0];
            gqe_pkg::CSR_TEXT_COLOR: color_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- input fields ----------------
   logic [15:0]                   in_code;
   gqe_pkg::glyph_type            in_glyph;
   logic [gqe_pkg::POS_W-1:0]     in_start_x;
   logic [gqe_pkg::POS_W-1:0]     in_start_y;

   assign in_code           = req_tdata[15:0];
   assign in_glyph.atlas_x  = req_tdata[26:16];
   assign in_glyph.atlas_y  = req_tdata[37:27];
   assign in_glyph.glyph_w  = req_tdata[45:38];
   assign in_glyph.glyph_h  = req_tdata[53:46];
   assign in_glyph.offset_x = req_tdata[61:54];
   assign in_glyph.offset_y = req_tdata[69:62];
   assign in_glyph.advance  = req_tdata[77:70];
   assign in_start_x        = req_tdata[101:78];
   assign in_start_y        = req_tdata[125:102];

   // ---------------- pipeline flow control ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, q_valid_ff;
   logic [2:0] q_cnt_ff;
   logic [gqe_pkg::CMD_W-1:0] s1_cmd_ff, s2_cmd_ff;
   logic req_accept, rsp_accept, q_take, q_free;
   logic s3_go, s3_free, s2_go, s2_free, s1_go, s1_free;

   assign rsp_accept = q_valid_ff && rsp_tready;
   assign q_take     = rsp_accept && (q_cnt_ff == gqe_pkg::VERT_LAST);
   assign q_free     = !q_valid_ff || q_take;
   assign s3_go      = s3_valid_ff && q_free;
   assign s3_free    = !s3_valid_ff || s3_go;
   assign s2_go      = s2_valid_ff && ((s2_cmd_ff != gqe_pkg::CMD_DRAW) || s3_free);
   assign s2_free    = !s2_valid_ff || s2_go;
   assign s1_go      = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s1_go;
   assign req_tready = s1_free;
   assign req_accept = req_tvalid && s1_free;

   // ---------------- glyph table ----------------
   gqe_pkg::glyph_type   table_mem [GLYPH_ENTRIES];
   logic [GLYPH_ENTRIES-1:0] entry_ok_ff;
   gqe_pkg::glyph_type   rd_glyph_ff;
   logic                 rd_hit_ff;
   logic                 load_we;
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     rd_addr;
   logic [15:0]          draw_code;

   assign load_we   = req_accept && (req_tuser == gqe_pkg::CMD_LOAD);
   assign wr_addr   = ({1'b0, in_code} < ENTRY_LIM) ? in_code[IDX_W-1:0] : '0;
   assign draw_code = {9'b0, in_code[6:0]};
   assign rd_addr   = ({1'b0, draw_code} < ENTRY_LIM) ? draw_code[IDX_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (load_we) begin
         table_mem[wr_addr] <= in_glyph;
      end
      if (req_accept) begin
         rd_glyph_ff <= table_mem[rd_addr];
         rd_hit_ff   <= entry_ok_ff[rd_addr];
      end
   end

   // entries never loaded read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ok_ff <= '0;
      end else if (load_we) begin
         entry_ok_ff[wr_addr] <= 1'b1;
      end
   end

   // ---------------- stage 1: item and glyph ----------------
   logic [gqe_pkg::POS_W-1:0] s1_start_x_ff, s1_start_y_ff;
   gqe_pkg::glyph_type        s1_glyph;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff     <= req_tuser;
         s1_start_x_ff <= in_start_x;
         s1_start_y_ff <= in_start_y;
      end
   end

   assign s1_glyph = rd_hit_ff ? rd_glyph_ff : '0;

   // ---------------- stage 2: scaled products ----------------
   logic signed [gqe_pkg::OFS_PROD_W-1:0] oxs_in, oys_in, s2_oxs_ff, s2_oys_ff;
   logic [gqe_pkg::DIM_PROD_W-1:0]        ws_in, hs_in, s2_ws_ff, s2_hs_ff;
   logic signed [gqe_pkg::ADV_PROD_W-1:0] advs_in, s2_advs_ff;
   logic signed [9:0]                     adv_sum;
   logic [gqe_pkg::TEX_W-1:0]             u0_in, v0_in, u1_in, v1_in;
   logic [gqe_pkg::TEX_W-1:0]             s2_u0_ff, s2_v0_ff, s2_u1_ff, s2_v1_ff;
   logic [gqe_pkg::POS_W-1:0]             s2_start_x_ff, s2_start_y_ff;

   always_comb begin
      oxs_in  = $signed({{13{s1_glyph.offset_x[7]}}, s1_glyph.offset_x})
              * $signed({9'b0, scale_ff});
      oys_in  = $signed({{13{s1_glyph.offset_y[7]}}, s1_glyph.offset_y})
              * $signed({9'b0, scale_ff});
      ws_in   = {12'b0, s1_glyph.glyph_w} * {8'b0, scale_ff};
      hs_in   = {12'b0, s1_glyph.glyph_h} * {8'b0, scale_ff};
      adv_sum = $signed({{2{kern_ff[7]}}, kern_ff}) + $signed({2'b0, s1_glyph.advance});
      advs_in = $signed({{12{adv_sum[9]}}, adv_sum}) * $signed({10'b0, scale_ff});
      u0_in   = {1'b0, s1_glyph.atlas_x};
      v0_in   = {1'b0, s1_glyph.atlas_y};
      u1_in   = u0_in + {4'b0, s1_glyph.glyph_w};
      v1_in   = v0_in + {4'b0, s1_glyph.glyph_h};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_cmd_ff     <= s1_cmd_ff;
         s2_start_x_ff <= s1_start_x_ff;
         s2_start_y_ff <= s1_start_y_ff;
         s2_oxs_ff     <= oxs_in;
         s2_oys_ff     <= oys_in;
         s2_ws_ff      <= ws_in;
         s2_hs_ff      <= hs_in;
         s2_advs_ff    <= advs_in;
         s2_u0_ff      <= u0_in;
         s2_v0_ff      <= v0_in;
         s2_u1_ff      <= u1_in;
         s2_v1_ff      <= v1_in;
      end
   end

   // ---------------- stage 3: pen and depth ----------------
   logic [gqe_pkg::POS_W-1:0] pen_x_ff, pen_y_ff, pen_x_in, pen_y_in;
   logic [gqe_pkg::POS_W-1:0] x0_in, y0_in;
   logic [DEPTH_W-1:0]        depth_ff, depth_in;
   logic [gqe_pkg::POS_W-1:0] s3_x0_ff, s3_y0_ff;
   logic [gqe_pkg::DIM_PROD_W-1:0] s3_ws_ff, s3_hs_ff;
   logic [gqe_pkg::TEX_W-1:0] s3_u0_ff, s3_v0_ff, s3_u1_ff, s3_v1_ff;
   logic [DEPTH_W-1:0]        s3_depth_ff;

   always_comb begin
      x0_in = gqe_pkg::sat_pos($signed({{2{pen_x_ff[23]}}, pen_x_ff})
                             + $signed({{5{s2_oxs_ff[20]}}, s2_oxs_ff}));
      y0_in = gqe_pkg::sat_pos($signed({{2{pen_y_ff[23]}}, pen_y_ff})
                             + $signed({{5{s2_oys_ff[20]}}, s2_oys_ff}));
      depth_in = (depth_ff >= DEPTH_TOP) ? DEPTH_W'(1) : depth_ff + DEPTH_W'(1);
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      case (s2_cmd_ff)
         gqe_pkg::CMD_START: begin
            pen_x_in = s2_start_x_ff;
            pen_y_in = s2_start_y_ff;
         end
         gqe_pkg::CMD_DRAW: begin
            pen_x_in = gqe_pkg::sat_pos($signed({{2{pen_x_ff[23]}}, pen_x_ff})
                                      + $signed({{4{s2_advs_ff[21]}}, s2_advs_ff}));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
         depth_ff <= '0;
      end else if (s2_go) begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         if (s2_cmd_ff == gqe_pkg::CMD_DRAW) begin
            depth_ff <= depth_in;
         end
      end
   end

   // only draws move on past the pen stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff <= s2_go && (s2_cmd_ff == gqe_pkg::CMD_DRAW);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go && (s2_cmd_ff == gqe_pkg::CMD_DRAW)) begin
         s3_x0_ff    <= x0_in;
         s3_y0_ff    <= y0_in;
         s3_ws_ff    <= s2_ws_ff;
         s3_hs_ff    <= s2_hs_ff;
         s3_u0_ff    <= s2_u0_ff;
         s3_v0_ff    <= s2_v0_ff;
         s3_u1_ff    <= s2_u1_ff;
         s3_v1_ff    <= s2_v1_ff;
         s3_depth_ff <= depth_in;
      end
   end

   // ---------------- stage 4: quad corners and vertex output ----------------
   logic [gqe_pkg::POS_W-1:0] x1_in, y1_in;
   logic [gqe_pkg::POS_W-1:0] q_x0_ff, q_y0_ff, q_x1_ff, q_y1_ff;
   logic [gqe_pkg::TEX_W-1:0] q_u0_ff, q_v0_ff, q_u1_ff, q_v1_ff;
   logic [DEPTH_W-1:0]        q_depth_ff;
   logic [2:0]                q_cnt_in;
   logic                      sel_x1, sel_y1;
   logic [gqe_pkg::POS_W-1:0] vert_x, vert_y;
   logic [gqe_pkg::TEX_W-1:0] tex_u, tex_v;

   always_comb begin
      x1_in = gqe_pkg::sat_pos($signed({{2{s3_x0_ff[23]}}, s3_x0_ff})
                             + $signed({6'b0, s3_ws_ff}));
      y1_in = gqe_pkg::sat_pos($signed({{2{s3_y0_ff[23]}}, s3_y0_ff})
                             + $signed({6'b0, s3_hs_ff}));
   end

   always_comb begin
      q_cnt_in = q_cnt_ff;
      if (q_take) begin
         q_cnt_in = gqe_pkg::VERT_0;
      end else if (rsp_accept) begin
         q_cnt_in = q_cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
         q_cnt_ff   <= gqe_pkg::VERT_0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         if (q_free) begin
            q_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_go) begin
         q_x0_ff    <= s3_x0_ff;
         q_y0_ff    <= s3_y0_ff;
         q_x1_ff    <= x1_in;
         q_y1_ff    <= y1_in;
         q_u0_ff    <= s3_u0_ff;
         q_v0_ff    <= s3_v0_ff;
         q_u1_ff    <= s3_u1_ff;
         q_v1_ff    <= s3_v1_ff;
         q_depth_ff <= s3_depth_ff;
      end
   end

   // vertex order: (x0,y0) (x0,y1) (x1,y0) (x0,y1) (x1,y0) (x1,y1)
   always_comb begin
      case (q_cnt_ff) inside
         gqe_pkg::VERT_2, gqe_pkg::VERT_4, gqe_pkg::VERT_LAST: sel_x1 = 1'b1;
         default:                                              sel_x1 = 1'b0;
      endcase
      case (q_cnt_ff) inside
         gqe_pkg::VERT_1, gqe_pkg::VERT_3, gqe_pkg::VERT_LAST: sel_y1 = 1'b1;
         default:                                              sel_y1 = 1'b0;
      endcase
   end

   assign vert_x = sel_x1 ? q_x1_ff : q_x0_ff;
   assign tex_u  = sel_x1 ? q_u1_ff : q_u0_ff;
   assign vert_y = sel_y1 ? q_y1_ff : q_y0_ff;
   assign tex_v  = sel_y1 ? q_v1_ff : q_v0_ff;

   assign rsp_tvalid = q_valid_ff;
   assign rsp_tlast  = (q_cnt_ff == gqe_pkg::VERT_LAST);
   assign rsp_tdata  = {1'b0, color_ff, gqe_pkg::DEPTH_IDX_W'(q_depth_ff),
                        tex_v, tex_u, vert_y, vert_x};

endmodule

// ===== hdl/gqe_checker.sv =====
`include "assert_macros.svh"

module gqe_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [gqe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);

   logic [2:0]                        vcnt_ff;
   logic [gqe_pkg::DEPTH_IDX_W-1:0]   depth_ff;
   logic [gqe_pkg::DEPTH_IDX_W-1:0]   depth;

   assign depth = rsp_tdata[86:72];

   // count vertices seen in the current quad
   always_ff @(posedge clock) begin
      if (reset) begin
         vcnt_ff <= gqe_pkg::VERT_0;
      end else if (rsp_tvalid && rsp_tready) begin
         vcnt_ff <= rsp_tlast ? gqe_pkg::VERT_0 : vcnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         depth_ff <= depth;
      end
   end

   `ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_tvalid, "output valid after reset")
   `ASSERT_CLK(a_hold_stalled, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled item changed")
   `ASSERT_CLK(a_last_on_sixth, clock, reset, rsp_tvalid |-> (rsp_tlast == (vcnt_ff == gqe_pkg::VERT_LAST)), "tlast not on sixth vertex")
   `ASSERT_CLK(a_depth_per_quad, clock, reset, rsp_tvalid && (vcnt_ff != gqe_pkg::VERT_0) |-> (depth == depth_ff), "depth changed within quad")
   `ASSERT_CLK(a_depth_nonzero, clock, reset, rsp_tvalid |-> (depth != '0), "depth index zero")

endmodule

bind glyph_quad_emitter gqe_checker u_gqe_checker (.*);
